FILE: rtl/core/clle_pkg.sv
// Shared constants, types and the control-store program of the liquid level estimator.
package clle_pkg;

  localparam int SENSORS   = 10;
  localparam int RAW_BITS  = 16;
  localparam int FIELD_W   = 16;
  localparam int RAW_W     = (RAW_BITS < FIELD_W) ? RAW_BITS : FIELD_W;
  localparam int IDX_W     = $clog2(SENSORS);
  localparam int CNT_W     = $clog2(SENSORS + 1);
  localparam int RADIX     = 4;
  localparam int DIV_STEPS = (RAW_W + RADIX - 1) / RADIX;
  localparam int DIV_W     = DIV_STEPS * RADIX;
  localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int ACC_W     = 32;
  localparam int IN_W      = 168;
  localparam int OUT_W     = 16;

  typedef enum logic [2:0] {
    ACT_CLEAR_ALL  = 3'd0,
    ACT_BASELINE   = 3'd1,
    ACT_MEASURE    = 3'd2,
    ACT_EVALUATE   = 3'd3,
    ACT_CLEAR_MEAS = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SCAN_COUNT = 3'd1,
    REG_ACTIVE     = 3'd2,
    REG_LEVEL_STEP = 3'd3,
    REG_MAX_LEVEL  = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_WAIT     = 4'd0,
    ST_DISPATCH = 4'd1,
    ST_CHECK    = 4'd2,
    ST_DLOAD    = 4'd3,
    ST_DSTEP    = 4'd4,
    ST_ACCUM    = 4'd5,
    ST_SETACC   = 4'd6,
    ST_EVAL     = 4'd7,
    ST_EVFIN    = 4'd8,
    ST_CLRALL   = 4'd9,
    ST_CLRMEAS  = 4'd10,
    ST_EMIT     = 4'd11
  } step_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_JUMP     = 3'd1,
    C_IN_FIRE  = 3'd2,
    C_DISPATCH = 3'd3,
    C_ZERO     = 3'd4,
    C_DIV_DONE = 3'd5,
    C_IDX_MORE = 3'd6,
    C_OUT_FREE = 3'd7
  } cond_t;

  typedef struct packed {
    step_t target;
    cond_t cond;
    logic  stay;
    logic  ld_item;
    logic  div_load;
    logic  div_step;
    logic  acc_add;
    logic  set_acc;
    logic  eval_step;
    logic  eval_fin;
    logic  clr_base;
    logic  clr_meas;
    logic  emit;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '0;
    w.target = ST_WAIT;
    w.cond   = C_NEXT;
    case (s)
      ST_WAIT: begin
        w.ld_item = 1'b1; w.cond = C_IN_FIRE; w.target = ST_DISPATCH; w.stay = 1'b1;
      end
      ST_DISPATCH: w.cond = C_DISPATCH;
      ST_CHECK: begin
        w.cond = C_ZERO; w.target = ST_EMIT;
      end
      ST_DLOAD: w.div_load = 1'b1;
      ST_DSTEP: begin
        w.div_step = 1'b1; w.cond = C_DIV_DONE; w.target = ST_ACCUM; w.stay = 1'b1;
      end
      ST_ACCUM: begin
        w.acc_add = 1'b1; w.cond = C_IDX_MORE; w.target = ST_DLOAD;
      end
      ST_SETACC: begin
        w.set_acc = 1'b1; w.cond = C_JUMP; w.target = ST_EMIT;
      end
      ST_EVAL: begin
        w.eval_step = 1'b1; w.cond = C_IDX_MORE; w.target = ST_EVAL;
      end
      ST_EVFIN: begin
        w.eval_fin = 1'b1; w.cond = C_JUMP; w.target = ST_EMIT;
      end
      ST_CLRALL: begin
        w.clr_base = 1'b1; w.clr_meas = 1'b1; w.cond = C_JUMP; w.target = ST_EMIT;
      end
      ST_CLRMEAS: begin
        w.clr_meas = 1'b1; w.cond = C_JUMP; w.target = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit = 1'b1; w.cond = C_OUT_FREE; w.target = ST_WAIT; w.stay = 1'b1;
      end
      default: begin
        w.cond = C_JUMP; w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/capacitive_liquid_level_estimator_top.sv
// Top level of the liquid level estimator: control-store sequencer and shared datapath.
//
//   Channel   Direction  Handshake            Words
//   s_*       in         s_tvalid/s_tready    action and ten raw counts per scan
//   m_*       out        m_tvalid/m_tready    one result per input word
//   cfg_*     in         cfg_we               register writes, no read-back
//
// A scan runs a load, four divider steps and an accumulate for each active sensor;
// the shared divider retires four quotient bits per step. An evaluate visits each
// active sensor once; clears, rejected scans and unused actions have no per-sensor
// steps. Reset is synchronous and zeroes both accumulator banks at once. A stalled
// output holds in its register while the next word is taken; the sequencer waits in
// its emit step only if a second result finds the register full.
module capacitive_liquid_level_estimator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // action[2:0], raw_0[18:3], raw_1, ... raw_9[162:147], zero fill
  input  logic [clle_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // scan_accepted[0], diff_ok[1], level[9:2], zero fill
  output logic [clle_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [7:0]                 cfg_data
);
  import clle_pkg::*;

  logic [7:0]             threshold;
  logic [7:0]             scan_count;
  logic [3:0]             active_sensors;
  logic [4:0]             level_step;
  logic [7:0]             max_level;

  step_t                  pc;
  step_t                  pc_next;
  ucode_t                 cw;

  logic [2:0]             act;
  logic [RAW_W-1:0]       raw [SENSORS];
  logic [ACC_W-1:0]       base_sum [SENSORS];
  logic [ACC_W-1:0]       meas_sum [SENSORS];
  logic [IDX_W-1:0]       idx;
  logic [DCNT_W-1:0]      dcnt;
  logic [7:0]             rem;
  logic [DIV_W-1:0]       quo;
  logic                   found;
  logic                   res_acc;
  logic                   res_ok;
  logic [7:0]             res_level;

  logic                   in_fire;
  logic                   out_free;
  logic [CNT_W-1:0]       n_act;
  logic [IDX_W-1:0]       idx_last;
  logic                   idx_more;
  logic                   any_zero;
  logic [7:0]             divisor;
  logic [8:0]             r9;
  logic [7:0]             rem_step;
  logic [DIV_W-1:0]       quo_step;
  logic [ACC_W-1:0]       diff;
  logic [8:0]             lvl_prod;
  logic [7:0]             lvl_sat;
  logic                   taken;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (pc == ST_WAIT);

  assign n_act    = (active_sensors == 4'd0) ? CNT_W'(1) :
                    (active_sensors > SENSORS) ? CNT_W'(SENSORS) : CNT_W'(active_sensors);
  assign idx_last = IDX_W'(n_act - CNT_W'(1));
  assign idx_more = (idx != idx_last);
  assign divisor  = (scan_count == 8'd0) ? 8'd1 : scan_count;

  always_comb begin
    any_zero = 1'b0;
    for (int i = 0; i < SENSORS; i++) begin
      if ((CNT_W'(i) < n_act) && (raw[i] == '0)) begin
        any_zero = 1'b1;
      end
    end
  end

  always_comb begin
    rem_step = rem;
    quo_step = quo;
    r9       = '0;
    for (int k = 0; k < RADIX; k++) begin
      r9       = {1'b0, rem_step} << 1;
      r9[0]    = quo_step[DIV_W-1];
      quo_step = quo_step << 1;
      if (r9 >= {1'b0, divisor}) begin
        r9          = r9 - {1'b0, divisor};
        quo_step[0] = 1'b1;
      end
      rem_step = r9[7:0];
    end
  end

  assign diff     = meas_sum[idx] - base_sum[idx];
  assign lvl_prod = 9'(idx) * 9'(level_step);
  assign lvl_sat  = (lvl_prod > 9'd255) ? 8'hFF : lvl_prod[7:0];

  always_comb begin
    cw = ucode_rom(pc);
  end

  always_comb begin
    case (cw.cond)
      C_NEXT:     taken = 1'b0;
      C_JUMP:     taken = 1'b1;
      C_IN_FIRE:  taken = in_fire;
      C_ZERO:     taken = any_zero;
      C_DIV_DONE: taken = (dcnt == DCNT_W'(DIV_STEPS - 1));
      C_IDX_MORE: taken = idx_more;
      C_OUT_FREE: taken = out_free;
      default:    taken = 1'b0;
    endcase
    if (cw.cond == C_DISPATCH) begin
      case (act) inside
        ACT_CLEAR_ALL:              pc_next = ST_CLRALL;
        ACT_BASELINE, ACT_MEASURE:  pc_next = ST_CHECK;
        ACT_EVALUATE:               pc_next = ST_EVAL;
        ACT_CLEAR_MEAS:             pc_next = ST_CLRMEAS;
        default:                    pc_next = ST_EMIT;
      endcase
    end else if (taken) begin
      pc_next = cw.target;
    end else if (cw.stay) begin
      pc_next = pc;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= 8'd0;
      scan_count     <= 8'd10;
      active_sensors <= 4'd10;
      level_step     <= 5'd10;
      max_level      <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold      <= cfg_data;
        REG_SCAN_COUNT: scan_count     <= cfg_data;
        REG_ACTIVE:     active_sensors <= cfg_data[3:0];
        REG_LEVEL_STEP: level_step     <= cfg_data[4:0];
        REG_MAX_LEVEL:  max_level      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cw.ld_item && in_fire) begin
      act <= s_tdata[2:0];
      for (int i = 0; i < SENSORS; i++) begin
        raw[i] <= s_tdata[3 + FIELD_W*i +: RAW_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      dcnt      <= '0;
      found     <= 1'b0;
      res_acc   <= 1'b0;
      res_ok    <= 1'b0;
      res_level <= '0;
    end else begin
      if (cw.ld_item && in_fire) begin
        idx       <= '0;
        found     <= 1'b0;
        res_acc   <= 1'b0;
        res_ok    <= (s_tdata[2:0] == ACT_EVALUATE);
        res_level <= '0;
      end
      if (cw.div_load) begin
        dcnt <= '0;
      end
      if (cw.div_step) begin
        dcnt <= dcnt + DCNT_W'(1);
      end
      if (cw.acc_add && idx_more) begin
        idx <= idx + IDX_W'(1);
      end
      if (cw.set_acc) begin
        res_acc <= 1'b1;
      end
      if (cw.eval_step) begin
        if (diff == '0) begin
          res_ok <= 1'b0;
        end
        if (!found && (diff < ACC_W'(threshold))) begin
          res_level <= lvl_sat;
          found     <= 1'b1;
        end
        if (idx_more) begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (cw.eval_fin && !found) begin
        res_level <= max_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.div_load) begin
      rem <= '0;
      quo <= DIV_W'(raw[idx]);
    end else if (cw.div_step) begin
      rem <= rem_step;
      quo <= quo_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSORS; i++) begin
        base_sum[i] <= '0;
        meas_sum[i] <= '0;
      end
    end else begin
      if (cw.acc_add) begin
        if (act == ACT_BASELINE) begin
          base_sum[idx] <= base_sum[idx] + ACC_W'(quo);
        end else begin
          meas_sum[idx] <= meas_sum[idx] + ACC_W'(quo);
        end
      end
      for (int i = 0; i < SENSORS; i++) begin
        if (cw.clr_base) begin
          base_sum[i] <= '0;
        end
        if (cw.clr_meas) begin
          meas_sum[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cw.emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && out_free) begin
      m_tdata <= {6'd0, res_level, res_ok, res_acc};
    end
  end

endmodule

FILE: rtl/core/clle_chk.sv
// Port-level checker for the liquid level estimator and its bind.
module clle_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [clle_pkg::OUT_W-1:0] m_tdata
);
  import clle_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result word valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result word changed.");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && (m_tdata[1] || (m_tdata[9:2] != 8'd0))))
    else $error("Accepted scan reported evaluate fields.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken again before the previous word was processed.");

endmodule

bind capacitive_liquid_level_estimator_top clle_chk u_clle_chk (.*);

FILE: tb/capacitive_liquid_level_estimator_top_test.sv
// Self-checking testbench that streams scans through the level estimator and predicts every result word.
module capacitive_liquid_level_estimator_top_test;
  import clle_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 700;
  localparam bit [2:0] NO_REG = 3'd5;

  typedef bit [SENSORS-1:0][15:0] scan_t;

  typedef struct packed {
    logic [7:0] level;
    logic       diff_ok;
    logic       accepted;
  } reading_t;

  class level_scoreboard;
    bit [31:0] base_sum [SENSORS];
    bit [31:0] meas_sum [SENSORS];
    bit [7:0]  threshold;
    bit [7:0]  scan_div;
    bit [3:0]  sensor_count;
    bit [4:0]  level_step;
    bit [7:0]  max_level;
    reading_t  readings_due [$];
    int        errors;

    function new();
      threshold = 8'd0;
      scan_div = 8'd10;
      sensor_count = 4'd10;
      level_step = 5'd10;
      max_level = 8'd100;
      for (int i = 0; i < SENSORS; i++) begin
        base_sum[i] = '0;
        meas_sum[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(bit [2:0] idx, bit [7:0] value);
      case (idx)
        REG_THRESHOLD:  threshold = value;
        REG_SCAN_COUNT: scan_div = value;
        REG_ACTIVE:     sensor_count = value[3:0];
        REG_LEVEL_STEP: level_step = value[4:0];
        REG_MAX_LEVEL:  max_level = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function void take_scan(logic [IN_W-1:0] word);
      reading_t  r;
      bit [15:0] raw [SENSORS];
      int        n;
      bit        any_zero;
      bit        found;
      bit [31:0] d;
      bit [31:0] div;
      bit [31:0] lvl;
      r = '0;
      n = (sensor_count == 0) ? 1 : ((sensor_count > SENSORS) ? SENSORS : sensor_count);
      for (int i = 0; i < SENSORS; i++) raw[i] = word[3 + 16*i +: 16];
      case (word[2:0])
        ACT_CLEAR_ALL: begin
          for (int i = 0; i < SENSORS; i++) begin
            base_sum[i] = '0;
            meas_sum[i] = '0;
          end
        end
        ACT_BASELINE, ACT_MEASURE: begin
          any_zero = 1'b0;
          for (int i = 0; i < n; i++) if (raw[i] == 0) any_zero = 1'b1;
          if (!any_zero) begin
            div = (scan_div == 0) ? 32'd1 : 32'(scan_div);
            for (int i = 0; i < n; i++) begin
              if (word[2:0] == ACT_BASELINE) base_sum[i] += 32'(raw[i]) / div;
              else meas_sum[i] += 32'(raw[i]) / div;
            end
            r.accepted = 1'b1;
          end
        end
        ACT_EVALUATE: begin
          r.diff_ok = 1'b1;
          found = 1'b0;
          for (int i = 0; i < n; i++) begin
            d = meas_sum[i] - base_sum[i];
            if (d == 0) r.diff_ok = 1'b0;
            if (!found && d < 32'(threshold)) begin
              lvl = 32'(i) * 32'(level_step);
              r.level = (lvl > 255) ? 8'd255 : lvl[7:0];
              found = 1'b1;
            end
          end
          if (!found) r.level = max_level;
        end
        ACT_CLEAR_MEAS: begin
          for (int i = 0; i < SENSORS; i++) meas_sum[i] = '0;
        end
        default: ;
      endcase
      readings_due.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_reading(logic [OUT_W-1:0] word);
      reading_t want;
      reading_t got;
      got = reading_t'(word[9:0]);
      if (readings_due.size() == 0) begin
        report($sformatf("result word %h arrived with nothing outstanding", word));
        return;
      end
      want = readings_due.pop_front();
      if (got.accepted !== want.accepted)
        report($sformatf("scan_accepted %b, expected %b", got.accepted, want.accepted));
      if (got.diff_ok !== want.diff_ok)
        report($sformatf("diff_ok %b, expected %b", got.diff_ok, want.diff_ok));
      if (got.level !== want.level)
        report($sformatf("level %0d, expected %0d", got.level, want.level));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [7:0]       cfg_data = '0;

  level_scoreboard sb;
  int words_sent = 0;
  int quiet = 0;
  bit calm = 1'b0;
  bit hold_output = 1'b0;

  capacitive_liquid_level_estimator_top dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reading(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (!rst);
    forever begin
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  function automatic scan_t fill_scan(bit [15:0] value, int zero_at);
    scan_t r;
    for (int i = 0; i < SENSORS; i++) r[i] = (i == zero_at) ? 16'd0 : value;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] scan_word(bit [2:0] act, scan_t r);
    logic [IN_W-1:0] w;
    w = '0;
    w[2:0] = act;
    w[3 +: SENSORS*16] = r;
    return w;
  endfunction

  task automatic send_scan(logic [IN_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_scan(word);
    words_sent++;
  endtask

  task automatic pause_input(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic offer(logic [IN_W-1:0] word, bit gappy);
    send_scan(word);
    if (gappy && !calm && $urandom_range(0, 2) == 0) pause_input($urandom_range(1, 18));
    else if (!calm && $urandom_range(0, 149) == 0) settle();
  endtask

  task automatic write_reg(bit [2:0] idx, bit [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(bit [7:0] thr, bit [7:0] div, bit [7:0] count, bit [7:0] step,
                           bit [7:0] top);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_SCAN_COUNT, div);
    write_reg(REG_ACTIVE, count);
    write_reg(REG_LEVEL_STEP, step);
    write_reg(REG_MAX_LEVEL, top);
    cfg_we <= 1'b0;
  endtask

  // Most sequences clear, take matching baseline and measure scans, then evaluate.
  // Sensors below the chosen height get a lift in the measure scans, the rest only jitter.
  task automatic run_phase(int items);
    int        target;
    int        height;
    int        reps;
    int        zero_at;
    bit        gappy;
    bit [15:0] floor_v [SENSORS];
    bit [15:0] lift [SENSORS];
    scan_t     r;
    target = words_sent + items;
    while (words_sent < target) begin
      gappy = $urandom_range(0, 1);
      height = $urandom_range(0, SENSORS);
      reps = $urandom_range(1, 3);
      for (int i = 0; i < SENSORS; i++) begin
        floor_v[i] = 16'($urandom_range(1, 40000));
        lift[i] = 16'($urandom_range(300, 25000));
      end
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < SENSORS; i++)
          r[i] = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
        offer(scan_word(3'($urandom_range(0, 7)), r), gappy);
      end else begin
        offer(scan_word(($urandom_range(0, 3) == 0) ? ACT_CLEAR_MEAS : ACT_CLEAR_ALL,
                        fill_scan(16'($urandom), -1)), gappy);
        repeat (reps) begin
          zero_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, SENSORS - 1) : -1;
          for (int i = 0; i < SENSORS; i++)
            r[i] = (i == zero_at) ? 16'd0 : floor_v[i] + 16'($urandom_range(0, 2));
          offer(scan_word(ACT_BASELINE, r), gappy);
        end
        repeat (reps) begin
          zero_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, SENSORS - 1) : -1;
          for (int i = 0; i < SENSORS; i++)
            r[i] = (i == zero_at) ? 16'd0 :
                   floor_v[i] + 16'($urandom_range(0, 2)) + ((i < height) ? lift[i] : 16'd0);
          offer(scan_word(ACT_MEASURE, r), gappy);
        end
        repeat ($urandom_range(1, 2))
          offer(scan_word(ACT_EVALUATE, fill_scan(16'($urandom), -1)), gappy);
      end
    end
  endtask

  initial begin
    scan_t r;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_scan(scan_word(ACT_EVALUATE, fill_scan(16'h0000, -1)));
    send_scan(scan_word(ACT_BASELINE, fill_scan(16'hFFFF, -1)));
    send_scan(scan_word(ACT_BASELINE, fill_scan(16'h1234, SENSORS - 1)));
    send_scan(scan_word(ACT_BASELINE, fill_scan(16'hFFFF, 0)));
    send_scan(scan_word(ACT_MEASURE, fill_scan(16'h0001, -1)));
    repeat (2) send_scan(scan_word(ACT_MEASURE, fill_scan(16'hFFFF, -1)));
    send_scan(scan_word(ACT_EVALUATE, fill_scan(16'h0000, -1)));
    send_scan(scan_word(ACT_CLEAR_MEAS, fill_scan(16'h5555, -1)));
    send_scan(scan_word(ACT_EVALUATE, fill_scan(16'hFFFF, -1)));
    for (int a = ACT_CLEAR_MEAS + 1; a < 8; a++)
      send_scan(scan_word(3'(a), fill_scan(16'hA5C3, -1)));
    send_scan(scan_word(ACT_CLEAR_ALL, fill_scan(16'hAAAA, -1)));
    send_scan(scan_word(ACT_EVALUATE, fill_scan(16'h0000, -1)));
    settle();

    // A zero divisor, an out-of-range sensor count and a step that saturates the level.
    write_reg(NO_REG, 8'hAA);
    configure(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    r = fill_scan(16'd1000, -1);
    r[SENSORS-1] = 16'd1;
    send_scan(scan_word(ACT_MEASURE, r));
    send_scan(scan_word(ACT_EVALUATE, fill_scan(16'h0000, -1)));
    settle();

    // A zero sensor count checks only the lowest electrode.
    configure(8'd3, 8'd255, 8'd0, 8'd5, 8'd9);
    send_scan(scan_word(ACT_BASELINE, fill_scan(16'hFFFF, 5)));
    send_scan(scan_word(ACT_EVALUATE, fill_scan(16'h0000, -1)));
    settle();

    configure(8'd40, 8'd4, 8'd10, 8'd10, 8'd100);
    hold_output = 1'b1;
    run_phase(250);
    settle();
    configure(8'd0, 8'd1, 8'd3, 8'd28, 8'd0);
    run_phase(250);
    settle();
    configure(8'd255, 8'd255, 8'd1, 8'd0, 8'd255);
    run_phase(250);
    settle();
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(250);
    settle();
    configure(8'd200, 8'd0, 8'd12, 8'd31, 8'd77);
    run_phase(250);
    settle();
    configure(8'($urandom), 8'($urandom_range(1, 8)), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(250);
    settle();
    calm = 1'b1;
    configure(8'($urandom_range(20, 255)), 8'($urandom_range(1, 6)), 8'd10, 8'($urandom),
              8'($urandom));
    run_phase(250);
    settle();

    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
